FILE: rtl/core/caption_608_pair_classifier_core_assert.svh
// assertion macros for the caption pair classifier core
`ifndef CAPTION_608_PAIR_CLASSIFIER_CORE_ASSERT_SVH
`define CAPTION_608_PAIR_CLASSIFIER_CORE_ASSERT_SVH
`ifndef SYNTH
`define C608PC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("c608pc assertion failed");
`define C608PC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c608pc implication failed");
`define C608PC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c608pc next-cycle check failed");
`else
`define C608PC_ASSERT(lbl, prop)
`define C608PC_ASSERT_IMP(lbl, ante, cons)
`define C608PC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/c608pc_pkg.sv
// shared types, constants and row map for the caption pair classifier
`timescale 1ns / 1ps
package c608pc_pkg;

  typedef enum logic [3:0] {
    CAT_SUPPRESSED   = 4'd0,
    CAT_PREAMBLE     = 4'd1,
    CAT_PREAMBLE_BAD = 4'd2,
    CAT_ATTRIBUTE    = 4'd3,
    CAT_COMMAND      = 4'd4,
    CAT_COMMAND_UNK  = 4'd5,
    CAT_SPECIAL_NA   = 4'd6,
    CAT_SPECIAL_SFM  = 4'd7,
    CAT_SPECIAL_PGD  = 4'd8,
    CAT_STANDARD     = 4'd9,
    CAT_TAB          = 4'd10,
    CAT_NONDATA      = 4'd11
  } cat_t;

  localparam logic [7:0] NULL_HDR_A = 8'hfa;
  localparam logic [7:0] NULL_HDR_B = 8'hfc;
  localparam logic [7:0] NULL_HDR_C = 8'hfd;
  localparam logic [6:0] BAD_PARITY_SUB = 7'h7f;

  localparam logic [6:0] B1_PAC_BASE = 7'h10;
  localparam logic [6:0] B1_SET_NA   = 7'h11;
  localparam logic [6:0] B1_SET_PGD  = 7'h13;
  localparam logic [6:0] B1_TAB      = 7'h17;
  localparam logic [6:0] B1_CMD_A    = 7'h14;
  localparam logic [6:0] B1_CMD_B    = 7'h15;
  localparam logic [6:0] B1_CMD_C    = 7'h1c;
  localparam logic [6:0] B1_STD_LO   = 7'h20;

  localparam logic [6:0] B2_PAC_LO   = 7'h40;
  localparam logic [6:0] B2_PAC_HI   = 7'h5f;
  localparam logic [6:0] B2_ATTR_LO  = 7'h20;
  localparam logic [6:0] B2_ATTR_HI  = 7'h2f;
  localparam logic [6:0] B2_ATTR17_LO = 7'h2e;
  localparam logic [6:0] B2_TAB_LO   = 7'h21;
  localparam logic [6:0] B2_TAB_HI   = 7'h23;

  localparam logic [3:0] PAC_IDX_NO_ROW = 4'd1;
  localparam logic [2:0] COLOR_WHITE    = 3'd6;
  localparam logic [4:0] STYLE_ITALIC   = 5'd14;
  localparam logic [4:0] STYLE_ITALIC_U = 5'd15;

  typedef struct packed {
    logic       suppress;
    logic [6:0] b1;
    logic [6:0] b2;
  } chk_t;

  typedef struct packed {
    cat_t       category;
    logic [3:0] preamble_index;
    logic [3:0] row;
    logic [2:0] color;
    logic [1:0] style;
    logic [4:0] indent;
    logic [3:0] command_index;
    logic [6:0] char_first;
    logic [6:0] char_second;
    logic [1:0] tab_spaces;
  } res_t;

  // screen row minus one for each preamble index
  function automatic logic [3:0] row_of(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0:    r = 4'd10;
      4'd2:    r = 4'd0;
      4'd3:    r = 4'd1;
      4'd4:    r = 4'd2;
      4'd5:    r = 4'd3;
      4'd6:    r = 4'd11;
      4'd7:    r = 4'd12;
      4'd8:    r = 4'd13;
      4'd9:    r = 4'd14;
      4'd10:   r = 4'd4;
      4'd11:   r = 4'd5;
      4'd12:   r = 4'd6;
      4'd13:   r = 4'd7;
      4'd14:   r = 4'd8;
      4'd15:   r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] color_of(input logic [4:0] v);
    logic [3:0] h;
    h = v[4:1];
    if (h >= 4'd1 && h <= 4'd6) begin
      return 3'(h - 4'd1);
    end
    return COLOR_WHITE;
  endfunction

  function automatic logic [1:0] style_of(input logic [4:0] v);
    logic [1:0] s;
    if (v == STYLE_ITALIC) begin
      s = 2'd2;
    end else if (v == STYLE_ITALIC_U) begin
      s = 2'd3;
    end else begin
      s = {1'b0, v[0]};
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/c608pc_check.sv
// header, parity and null padding checks on one caption triple
`timescale 1ns / 1ps
module c608pc_check (
  input  logic              [7:0] header_byte,
  input  logic              [7:0] first_byte,
  input  logic              [7:0] second_byte,
  input  logic                    skip_packet_checks,
  output c608pc_pkg::chk_t        chk
);

  logic       hdr_bad;
  logic       b2_par_bad;
  logic [6:0] b1_fix;
  logic       null_pad;

  always_comb begin
    hdr_bad    = !header_byte[2] || (header_byte[1:0] != 2'd0);
    b2_par_bad = !(^second_byte);
    b1_fix     = (^first_byte) ? first_byte[6:0] : c608pc_pkg::BAD_PARITY_SUB;
    null_pad   = ((header_byte == c608pc_pkg::NULL_HDR_A) ||
                  (header_byte == c608pc_pkg::NULL_HDR_B) ||
                  (header_byte == c608pc_pkg::NULL_HDR_C)) &&
                 (b1_fix == 7'd0) && (second_byte[6:0] == 7'd0);
    if (skip_packet_checks) begin
      chk.suppress = 1'b0;
      chk.b1       = first_byte[6:0];
    end else begin
      chk.suppress = hdr_bad || b2_par_bad || null_pad;
      chk.b1       = b1_fix;
    end
    chk.b2 = second_byte[6:0];
  end

endmodule

FILE: rtl/core/c608pc_decode.sv
// classification of a checked byte pair into category and fields
`timescale 1ns / 1ps
module c608pc_decode (
  input  c608pc_pkg::chk_t chk,
  output c608pc_pkg::res_t res
);

  logic [6:0] b1;
  logic [6:0] b2;
  logic       is_pac;
  logic       is_attr;
  logic       is_cmd;
  logic [3:0] pac_idx;
  logic [4:0] pac_v;
  logic [4:0] attr_v;

  always_comb begin
    b1 = chk.b1;
    b2 = chk.b2;
    is_pac  = ((b1 == c608pc_pkg::B1_PAC_BASE) && (b2 >= c608pc_pkg::B2_PAC_LO) &&
               (b2 <= c608pc_pkg::B2_PAC_HI)) ||
              ((b1 >= c608pc_pkg::B1_SET_NA) && (b1 <= c608pc_pkg::B1_TAB) &&
               (b2 >= c608pc_pkg::B2_PAC_LO));
    is_attr = ((b1 == c608pc_pkg::B1_SET_NA) && (b2 >= c608pc_pkg::B2_ATTR_LO) &&
               (b2 <= c608pc_pkg::B2_ATTR_HI)) ||
              ((b1 == c608pc_pkg::B1_TAB) && (b2 >= c608pc_pkg::B2_ATTR17_LO) &&
               (b2 <= c608pc_pkg::B2_ATTR_HI));
    is_cmd  = (b1 == c608pc_pkg::B1_CMD_A) || (b1 == c608pc_pkg::B1_CMD_B) ||
              (b1 == c608pc_pkg::B1_CMD_C);
    pac_idx = {b1[2:0], b2[5]};
    pac_v   = b2[4:0];
    attr_v  = {1'b0, b2[3:0]};

    res.category       = c608pc_pkg::CAT_SUPPRESSED;
    res.preamble_index = 4'd0;
    res.row            = 4'd0;
    res.color          = 3'd0;
    res.style          = 2'd0;
    res.indent         = 5'd0;
    res.command_index  = 4'd0;
    res.char_first     = 7'd0;
    res.char_second    = 7'd0;
    res.tab_spaces     = 2'd0;

    if (!chk.suppress) begin
      if (is_pac) begin
        res.preamble_index = pac_idx;
        if (pac_idx == c608pc_pkg::PAC_IDX_NO_ROW) begin
          res.category = c608pc_pkg::CAT_PREAMBLE_BAD;
        end else begin
          res.category = c608pc_pkg::CAT_PREAMBLE;
          res.row      = c608pc_pkg::row_of(pac_idx);
          res.color    = c608pc_pkg::color_of(pac_v);
          res.style    = c608pc_pkg::style_of(pac_v);
          res.indent   = pac_v[4] ? {pac_v[3:0], 1'b0} : 5'd0;
        end
      end else if (is_attr) begin
        res.category = c608pc_pkg::CAT_ATTRIBUTE;
        res.color    = c608pc_pkg::color_of(attr_v);
        res.style    = c608pc_pkg::style_of(attr_v);
      end else if (is_cmd) begin
        if ((b2 >= c608pc_pkg::B2_ATTR_LO) && (b2 <= c608pc_pkg::B2_ATTR_HI)) begin
          res.category      = c608pc_pkg::CAT_COMMAND;
          res.command_index = b2[3:0];
        end else begin
          res.category = c608pc_pkg::CAT_COMMAND_UNK;
        end
      end else if ((b1 >= c608pc_pkg::B1_SET_NA) && (b1 <= c608pc_pkg::B1_SET_PGD)) begin
        case (b1[1:0])
          2'd1:    res.category = c608pc_pkg::CAT_SPECIAL_NA;
          2'd2:    res.category = c608pc_pkg::CAT_SPECIAL_SFM;
          default: res.category = c608pc_pkg::CAT_SPECIAL_PGD;
        endcase
      end else if (b1 >= c608pc_pkg::B1_STD_LO) begin
        res.category    = c608pc_pkg::CAT_STANDARD;
        res.char_first  = b1;
        res.char_second = b2;
      end else if ((b1 == c608pc_pkg::B1_TAB) && (b2 >= c608pc_pkg::B2_TAB_LO) &&
                   (b2 <= c608pc_pkg::B2_TAB_HI)) begin
        res.category   = c608pc_pkg::CAT_TAB;
        res.tab_spaces = b2[1:0];
      end else begin
        res.category = c608pc_pkg::CAT_NONDATA;
      end
    end
  end

endmodule

FILE: rtl/core/caption_608_pair_classifier_core.sv
// top level of the caption pair classifier: input register, decode, result register
//
// one transaction on the in_ channel carries a caption triple (header byte,
// two data bytes with parity in bit 7) and a flag that bypasses the packet
// checks; one transaction on the out_ channel carries the category and the
// decoded fields for that triple, in order, one result per input
// path: a triple accepted on in_ is held in the input register, decoded, and
// then captured in the result register, from which it is offered on out_
// throughput: one triple per cycle while out_ready stays high, set by the single
// decode stage between the two registers
// both registers use valid and ready; in_ready stays high while the input
// register is empty or moving forward, so a stalled receiver only blocks the
// input once both registers hold a transaction
// reset: rst_n low at a clock edge empties both registers; out_valid drops
// and in_ready rises in the next cycle, with no warm-up
// when out_valid is high and out_ready is low the result and all fields hold steady
`timescale 1ns / 1ps
`include "caption_608_pair_classifier_core_assert.svh"
module caption_608_pair_classifier_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_header_byte,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic       in_skip_packet_checks,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_category,
  output logic [3:0] out_preamble_index,
  output logic [3:0] out_row,
  output logic [2:0] out_color,
  output logic [1:0] out_style,
  output logic [4:0] out_indent,
  output logic [3:0] out_command_index,
  output logic [6:0] out_char_first,
  output logic [6:0] out_char_second,
  output logic [1:0] out_tab_spaces
);

  logic             stg_valid_r;
  logic [7:0]       hdr_r;
  logic [7:0]       b1_r;
  logic [7:0]       b2_r;
  logic             skip_r;
  logic             out_valid_r;
  c608pc_pkg::res_t res_r;
  c608pc_pkg::chk_t chk;
  c608pc_pkg::res_t res_nxt;
  logic             stg_ready;

  assign stg_ready = !out_valid_r || out_ready;
  assign in_ready  = !stg_valid_r || stg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hdr_r  <= in_header_byte;
      b1_r   <= in_first_byte;
      b2_r   <= in_second_byte;
      skip_r <= in_skip_packet_checks;
    end
  end

  c608pc_check u_check (
    .header_byte        (hdr_r),
    .first_byte         (b1_r),
    .second_byte        (b2_r),
    .skip_packet_checks (skip_r),
    .chk                (chk)
  );

  c608pc_decode u_decode (
    .chk (chk),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_ready) begin
      out_valid_r <= stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid_r && stg_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_category       = res_r.category;
  assign out_preamble_index = res_r.preamble_index;
  assign out_row            = res_r.row;
  assign out_color          = res_r.color;
  assign out_style          = res_r.style;
  assign out_indent         = res_r.indent;
  assign out_command_index  = res_r.command_index;
  assign out_char_first     = res_r.char_first;
  assign out_char_second    = res_r.char_second;
  assign out_tab_spaces     = res_r.tab_spaces;

  `C608PC_ASSERT_IMP(a_stall_full, !in_ready, stg_valid_r && out_valid_r && !out_ready)
  `C608PC_ASSERT_NEXT(a_stage_moves, stg_valid_r && stg_ready, out_valid_r)
  `C608PC_ASSERT_IMP(a_suppressed_zero,
    out_valid_r && (res_r.category == c608pc_pkg::CAT_SUPPRESSED),
    (res_r.preamble_index == 4'd0) && (res_r.char_first == 7'd0) && (res_r.tab_spaces == 2'd0))
  `C608PC_ASSERT_IMP(a_std_chars,
    out_valid_r && (res_r.category == c608pc_pkg::CAT_STANDARD),
    res_r.char_first >= c608pc_pkg::B1_STD_LO)
  `C608PC_ASSERT(a_row_range, !out_valid_r || (res_r.row <= 4'd14))

endmodule

FILE: bench/c608pc_checker.sv
// checker for the caption pair classifier: predicts each result and compares it
`timescale 1ns / 1ps
module c608pc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_header_byte,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic       in_skip_packet_checks,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_category,
  input  logic [3:0] out_preamble_index,
  input  logic [3:0] out_row,
  input  logic [2:0] out_color,
  input  logic [1:0] out_style,
  input  logic [4:0] out_indent,
  input  logic [3:0] out_command_index,
  input  logic [6:0] out_char_first,
  input  logic [6:0] out_char_second,
  input  logic [1:0] out_tab_spaces,
  output int         fail_count,
  output int         pending
);

  localparam int ROW_MAP [0:15] = '{11, -1, 1, 2, 3, 4, 12, 13, 14, 15, 5, 6, 7, 8, 9, 10};
  localparam logic [6:0] PARITY_FILL = 7'h7f;
  localparam logic [2:0] PEN_WHITE = 3'd6;
  localparam int REPORT_LIMIT = 10;

  c608pc_pkg::res_t pending_classes[$];

  function automatic logic [2:0] pen_color(input logic [4:0] v);
    logic [3:0] h;
    h = v[4:1];
    return (h == 4'd0 || h > 4'd6) ? PEN_WHITE : 3'(h - 4'd1);
  endfunction

  function automatic logic [1:0] pen_style(input logic [4:0] v);
    case (v)
      5'd14:   return 2'd2;
      5'd15:   return 2'd3;
      default: return v[0] ? 2'd1 : 2'd0;
    endcase
  endfunction

  function automatic c608pc_pkg::res_t classify_pair(input logic [7:0] hdr,
                                                     input logic [7:0] raw1,
                                                     input logic [7:0] raw2,
                                                     input logic bypass);
    c608pc_pkg::res_t r;
    logic [6:0] c1;
    logic [6:0] c2;
    logic [4:0] v;
    logic [3:0] idx;
    int mapped;
    r = '0;
    r.category = c608pc_pkg::CAT_SUPPRESSED;
    c1 = raw1[6:0];
    c2 = raw2[6:0];
    if (!bypass) begin
      if (!hdr[2] || hdr[1:0] != 2'b00) return r;
      if (!(^raw2)) return r;
      if (!(^raw1)) c1 = PARITY_FILL;
      if ((hdr == c608pc_pkg::NULL_HDR_A || hdr == c608pc_pkg::NULL_HDR_B ||
           hdr == c608pc_pkg::NULL_HDR_C) &&
          c1 == 7'h00 && c2 == 7'h00) return r;
    end
    if ((c1 == 7'h10 && c2 >= 7'h40 && c2 <= 7'h5f) ||
        (c1 >= 7'h11 && c1 <= 7'h17 && c2 >= 7'h40)) begin
      idx = {c1[2:0], c2[5]};
      mapped = ROW_MAP[idx];
      r.preamble_index = idx;
      if (mapped < 1) begin
        r.category = c608pc_pkg::CAT_PREAMBLE_BAD;
      end else begin
        v = c2[4:0];
        r.category = c608pc_pkg::CAT_PREAMBLE;
        r.row = 4'(mapped - 1);
        r.color = pen_color(v);
        r.style = pen_style(v);
        r.indent = (v >= 5'd16) ? 5'((v - 5'd16) * 2) : 5'd0;
      end
    end else if ((c1 == 7'h11 && c2 >= 7'h20 && c2 <= 7'h2f) ||
                 (c1 == 7'h17 && c2 >= 7'h2e && c2 <= 7'h2f)) begin
      v = 5'(c2 - 7'h20);
      r.category = c608pc_pkg::CAT_ATTRIBUTE;
      r.color = pen_color(v);
      r.style = pen_style(v);
    end else if (c1 == 7'h14 || c1 == 7'h15 || c1 == 7'h1c) begin
      if (c2 >= 7'h20 && c2 <= 7'h2f) begin
        r.category = c608pc_pkg::CAT_COMMAND;
        r.command_index = c2[3:0];
      end else begin
        r.category = c608pc_pkg::CAT_COMMAND_UNK;
      end
    end else if (c1 >= 7'h11 && c1 <= 7'h13) begin
      case (c1)
        7'h11:   r.category = c608pc_pkg::CAT_SPECIAL_NA;
        7'h12:   r.category = c608pc_pkg::CAT_SPECIAL_SFM;
        default: r.category = c608pc_pkg::CAT_SPECIAL_PGD;
      endcase
    end else if (c1 >= 7'h20) begin
      r.category = c608pc_pkg::CAT_STANDARD;
      r.char_first = c1;
      r.char_second = c2;
    end else if (c1 == 7'h17 && c2 >= 7'h21 && c2 <= 7'h23) begin
      r.category = c608pc_pkg::CAT_TAB;
      r.tab_spaces = c2[1:0];
    end else begin
      r.category = c608pc_pkg::CAT_NONDATA;
    end
    return r;
  endfunction

  task automatic report(input string what, input c608pc_pkg::res_t r);
    $display("  %s: cat %0d pidx %0d row %0d color %0d style %0d indent %0d cmd %0d",
             what, r.category, r.preamble_index, r.row, r.color, r.style, r.indent,
             r.command_index);
    $display("  %s: char1 %h char2 %h tab %0d", what, r.char_first, r.char_second,
             r.tab_spaces);
  endtask

  c608pc_pkg::res_t got;
  c608pc_pkg::res_t want;

  always_comb begin
    got.category = c608pc_pkg::cat_t'(out_category);
    got.preamble_index = out_preamble_index;
    got.row = out_row;
    got.color = out_color;
    got.style = out_style;
    got.indent = out_indent;
    got.command_index = out_command_index;
    got.char_first = out_char_first;
    got.char_second = out_char_second;
    got.tab_spaces = out_tab_spaces;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_classes.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("%0t: result transaction with nothing outstanding", $realtime);
            report("got", got);
          end
          fail_count++;
        end else begin
          want = pending_classes.pop_front();
          if (got !== want) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              report("expected", want);
              report("actual", got);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_classes.push_back(classify_pair(in_header_byte, in_first_byte,
                                                in_second_byte, in_skip_packet_checks));
      end
    end
    pending <= pending_classes.size();
  end

endmodule

FILE: bench/tb.sv
// top of the caption pair classifier testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 330;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 200;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_header_byte;
  logic [7:0] in_first_byte;
  logic [7:0] in_second_byte;
  logic       in_skip_packet_checks;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_category;
  logic [3:0] out_preamble_index;
  logic [3:0] out_row;
  logic [2:0] out_color;
  logic [1:0] out_style;
  logic [4:0] out_indent;
  logic [3:0] out_command_index;
  logic [6:0] out_char_first;
  logic [6:0] out_char_second;
  logic [1:0] out_tab_spaces;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int accepted_in = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  caption_608_pair_classifier_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_header_byte        (in_header_byte),
    .in_first_byte         (in_first_byte),
    .in_second_byte        (in_second_byte),
    .in_skip_packet_checks (in_skip_packet_checks),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_category          (out_category),
    .out_preamble_index    (out_preamble_index),
    .out_row               (out_row),
    .out_color             (out_color),
    .out_style             (out_style),
    .out_indent            (out_indent),
    .out_command_index     (out_command_index),
    .out_char_first        (out_char_first),
    .out_char_second       (out_char_second),
    .out_tab_spaces        (out_tab_spaces)
  );

  c608pc_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_header_byte        (in_header_byte),
    .in_first_byte         (in_first_byte),
    .in_second_byte        (in_second_byte),
    .in_skip_packet_checks (in_skip_packet_checks),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_category          (out_category),
    .out_preamble_index    (out_preamble_index),
    .out_row               (out_row),
    .out_color             (out_color),
    .out_style             (out_style),
    .out_indent            (out_indent),
    .out_command_index     (out_command_index),
    .out_char_first        (out_char_first),
    .out_char_second       (out_char_second),
    .out_tab_spaces        (out_tab_spaces),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls plus one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_in >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      accepted_in <= accepted_in + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("caption_608_pair_classifier_core verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] odd_byte(input logic [6:0] d);
    return {~^d, d};
  endfunction

  task automatic send_triple(input logic [7:0] h, input logic [7:0] b1,
                             input logic [7:0] b2, input logic s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_header_byte <= h;
    in_first_byte <= b1;
    in_second_byte <= b2;
    in_skip_packet_checks <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_directed();
    // header checks, parity handling and null padding
    send_triple(8'h00, odd_byte(7'h41), odd_byte(7'h42), 1'b0);
    send_triple(8'h05, odd_byte(7'h41), odd_byte(7'h42), 1'b0);
    send_triple(8'hfc, odd_byte(7'h41), 8'h42, 1'b0);
    send_triple(8'hfc, 8'h41, odd_byte(7'h42), 1'b0);
    send_triple(c608pc_pkg::NULL_HDR_A, 8'h80, 8'h80, 1'b0);
    send_triple(c608pc_pkg::NULL_HDR_B, 8'h80, 8'h80, 1'b0);
    send_triple(c608pc_pkg::NULL_HDR_C, 8'h80, 8'h80, 1'b0);
    send_triple(8'h04, 8'h80, 8'h80, 1'b0);
    send_triple(8'hff, 8'hff, 8'hff, 1'b1);
    send_triple(8'h00, 8'h00, 8'h00, 1'b1);
    // decode classes on bare pairs
    send_triple(8'h00, 8'h10, 8'h40, 1'b1);
    send_triple(8'h00, 8'h10, 8'h60, 1'b1);
    send_triple(8'h00, 8'h97, 8'hff, 1'b1);
    send_triple(8'h00, 8'h12, 8'h5e, 1'b1);
    send_triple(8'h00, 8'h11, 8'h2e, 1'b1);
    send_triple(8'h00, 8'h17, 8'h2f, 1'b1);
    send_triple(8'h00, 8'h14, 8'h2c, 1'b1);
    send_triple(8'h00, 8'h1c, 8'h20, 1'b1);
    send_triple(8'h00, 8'h15, 8'h30, 1'b1);
    send_triple(8'h00, 8'h11, 8'h30, 1'b1);
    send_triple(8'h00, 8'h12, 8'h3f, 1'b1);
    send_triple(8'h00, 8'h13, 8'h31, 1'b1);
    send_triple(8'hfc, odd_byte(7'h17), odd_byte(7'h21), 1'b0);
    send_triple(8'h00, 8'h17, 8'h23, 1'b1);
    send_triple(8'h00, 8'h7f, 8'h00, 1'b1);
  endtask

  task automatic send_random();
    logic [7:0] h;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [7:0] b1;
    logic [7:0] b2;
    int pick;
    pick = $urandom_range(99);
    h = 8'($urandom);
    if (pick < 80) begin
      h[2] = 1'b1;
      h[1:0] = 2'b00;
    end else if (pick < 90) begin
      case ($urandom_range(2))
        0:       h = c608pc_pkg::NULL_HDR_A;
        1:       h = c608pc_pkg::NULL_HDR_B;
        default: h = c608pc_pkg::NULL_HDR_C;
      endcase
    end
    case ($urandom_range(9))
      0:       d1 = 7'h10;
      1, 2, 3: d1 = 7'(7'h11 + $urandom_range(6));
      4:       d1 = 7'h1c;
      5:       d1 = 7'(7'h14 + $urandom_range(1));
      6:       d1 = 7'($urandom_range(31));
      default: d1 = 7'($urandom_range(127, 32));
    endcase
    case ($urandom_range(9))
      0, 1, 2: d2 = 7'(7'h20 + $urandom_range(15));
      3, 4, 5: d2 = 7'(7'h40 + $urandom_range(63));
      6:       d2 = 7'(7'h21 + $urandom_range(2));
      default: d2 = 7'($urandom);
    endcase
    if (pick >= 80 && pick < 90 && $urandom_range(1) == 0) begin
      d1 = 7'h00;
      d2 = 7'h00;
    end
    b1 = odd_byte(d1);
    b2 = odd_byte(d2);
    if ($urandom_range(99) < 12) b1[7] = ~b1[7];
    if ($urandom_range(99) < 8) b2[7] = ~b2[7];
    send_triple(h, b1, b2, ($urandom_range(99) < 20));
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_header_byte <= 8'h00;
    in_first_byte <= 8'h00;
    in_second_byte <= 8'h00;
    in_skip_packet_checks <= 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 79;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();
    repeat (ITEMS_PER_PHASE) send_random();
    send_idle_pct = 79;
    recv_idle_pct = 18;
    repeat (ITEMS_PER_PHASE) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (ITEMS_PER_PHASE) send_random();
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("caption_608_pair_classifier_core verification clean");
    end else begin
      $display("caption_608_pair_classifier_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/c608pc_pkg.sv
rtl/core/c608pc_check.sv
rtl/core/c608pc_decode.sv
rtl/core/caption_608_pair_classifier_core.sv
bench/c608pc_checker.sv
bench/tb.sv
